FILE: src/esps_pkg.sv
// Shared constants and config indexes for the eight-sample pulse sum.
package esps_pkg;

  localparam int unsigned WINDOW_LEN = 8;
  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned IDX_W      = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W      = 15;
  localparam int unsigned PED_W      = 12;
  localparam int unsigned PED_SHIFT  = 3;
  localparam int unsigned CALC_W     = SUM_W + 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEDESTAL = 1'b0,
    CFG_SUM_MODE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PED_W-1:0] pedestal;
    logic             sum_mode;
  } esps_cfg_t;

endpackage

FILE: src/eight_sample_pulse_sum.sv
// Eight-sample pulse sum: takes one 12-bit ADC sample per cycle while the
// input is not stalled, sums windows of eight samples and gives one
// pedestal-subtracted, zero-clamped and saturated word per window on its
// last sample. A sample is registered at the input, processed against the
// window state once the output register is free, and the result is held in
// an output register. A stalled output word holds back the input only once
// the input register also holds a sample. The configuration port is always
// ready. It is to be written only while idle; the block itself does not
// enforce this.
module eight_sample_pulse_sum import esps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADC_BITS-1:0]   adc_sample_i,
  input  logic                  window_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SUM_W-1:0]      window_sum_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic                in_valid_q;
  logic [ADC_BITS-1:0] sample_q;
  logic                start_q;
  logic                out_valid_q;
  logic [SUM_W-1:0]    window_sum_q;
  esps_cfg_t           cfg_q;
  logic                out_free, proc;
  logic                res_valid;
  logic [SUM_W-1:0]    res;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign proc        = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PEDESTAL: cfg_q.pedestal <= cfg_data_i[PED_W-1:0];
        CFG_SUM_MODE: cfg_q.sum_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      sample_q <= adc_sample_i;
      start_q  <= window_start_i;
    end
  end

  esps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (proc),
    .sample_i    (sample_q),
    .start_i     (start_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      window_sum_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_sum_o = window_sum_q;

endmodule

FILE: src/esps_core.sv
// Window state and per-sample sum, rise check and pedestal subtraction.
module esps_core import esps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [ADC_BITS-1:0] sample_i,
  input  logic                start_i,
  input  esps_cfg_t           cfg_i,
  output logic                res_valid_o,
  output logic [SUM_W-1:0]    res_o
);

  logic [IDX_W-1:0]    idx_q, idx_d, idx;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [ADC_BITS-1:0] prev_q;
  logic                rise_q, rise_d;
  logic [CALC_W-1:0]   total, sub, diff;
  logic                zero_out;

  assign idx = start_i ? '0 : idx_q;

  always_comb begin
    total    = CALC_W'(sum_q) + CALC_W'(sample_i);
    sub      = CALC_W'(cfg_i.pedestal) << PED_SHIFT;
    diff     = (total > sub) ? total - sub : '0;
    zero_out = !cfg_i.sum_mode && (sample_i >= prev_q) && !rise_q;
    res_o    = '0;
    if (!zero_out) begin
      res_o = (diff > CALC_W'(SUM_MAX)) ? SUM_MAX : diff[SUM_W-1:0];
    end
    res_valid_o = (idx == LAST_IDX);
  end

  always_comb begin
    sum_d  = total[SUM_W-1:0];
    rise_d = rise_q;
    idx_d  = idx + IDX_W'(1);
    if (idx == '0) begin
      sum_d  = SUM_W'(sample_i);
      rise_d = 1'b0;
    end else if (idx == LAST_IDX) begin
      sum_d = res_o;
      idx_d = '0;
    end else if (idx == IDX_W'(1) && sample_i > prev_q) begin
      rise_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      sum_q  <= '0;
      prev_q <= '0;
      rise_q <= 1'b0;
    end else if (en_i) begin
      idx_q  <= idx_d;
      sum_q  <= sum_d;
      prev_q <= sample_i;
      rise_q <= rise_d;
    end
  end

endmodule

FILE: src/esps_checker.sv
// Port-level checks for the eight-sample pulse sum, bound to the top level.
module esps_checker import esps_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [SUM_W-1:0]      window_sum_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_sum_o))
    else $error("output word dropped or changed while stalled");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_sum_o <= SUM_W'(WINDOW_LEN * ((1 << ADC_BITS) - 1)))
    else $error("window sum above the largest possible window total");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && $past(in_valid_i && !in_stall_o) |-> in_stall_o)
    else $error("input taken with a stalled output and a full input stage");

  a_idle_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register is empty");

endmodule

bind eight_sample_pulse_sum esps_checker u_esps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .window_sum_o (window_sum_o)
);

FILE: test/tb_eight_sample_pulse_sum.sv
// Testbench for the eight-sample pulse sum: random sample windows checked against a predictor.
module tb_eight_sample_pulse_sum import esps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit MODE_RISE_FALL = 1'b0;
  localparam bit MODE_PLAIN     = 1'b1;
  localparam int PED_MAX        = (1 << PED_W) - 1;
  localparam int ADC_MAX        = (1 << ADC_BITS) - 1;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_LIMIT     = 3000;
  localparam int PHASE_SAMPLES  = 160;
  localparam int NUM_PHASES     = 8;

  localparam int SHAPE_RANDOM   = 0;
  localparam int SHAPE_RISING   = 1;
  localparam int SHAPE_FALLING  = 2;
  localparam int SHAPE_FLAT     = 3;
  localparam int SHAPE_PULSE    = 4;
  localparam int SHAPE_EXTREME  = 5;
  localparam int SHAPE_TINY     = 6;
  localparam int SHAPE_COUNT    = 7;

  class pulse_sum_scoreboard;
    logic [PED_W-1:0]    pedestal;
    logic                sum_mode;
    logic [IDX_W-1:0]    position;
    logic [SUM_W-1:0]    partial_sum;
    logic [ADC_BITS-1:0] last_sample;
    bit                  rise_seen;
    logic [SUM_W-1:0]    sums_due[$];
    int                  errors;
    int                  sums_checked;

    function new();
      pedestal     = '0;
      sum_mode     = MODE_RISE_FALL;
      position     = '0;
      partial_sum  = '0;
      last_sample  = '0;
      rise_seen    = 1'b0;
      errors       = 0;
      sums_checked = 0;
    endfunction

    function void note_sample(logic [ADC_BITS-1:0] s, logic start);
      logic [IDX_W-1:0] pos;
      int total;
      int deduct;
      int sum;
      pos = start ? '0 : position;
      if (pos == 0) begin
        partial_sum = SUM_W'(s);
        rise_seen   = 1'b0;
      end else if (pos != LAST_IDX) begin
        if (pos == 1 && s > partial_sum) rise_seen = 1'b1;
        partial_sum = partial_sum + SUM_W'(s);
      end else begin
        // mode 0: flat or rising tail with no early rise counts as no pulse
        if (sum_mode == MODE_RISE_FALL && s >= last_sample && !rise_seen) begin
          sum = 0;
        end else begin
          total  = int'(partial_sum) + int'(s);
          deduct = (1 << PED_SHIFT) * int'(pedestal);
          sum    = (total > deduct) ? total - deduct : 0;
          if (sum > int'(SUM_MAX)) sum = int'(SUM_MAX);
        end
        partial_sum = SUM_W'(sum);
        sums_due.insert(sums_due.size(), SUM_W'(sum));
      end
      last_sample = s;
      position    = pos + 1'b1;
    endfunction

    task report(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_sum(logic [SUM_W-1:0] got);
      logic [SUM_W-1:0] want;
      if (sums_due.size() == 0) begin
        report("window sum with none due", got, '0);
      end else begin
        want = sums_due.pop_front();
        sums_checked++;
        if (got !== want) report("window sum", got, want);
      end
    endtask
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [ADC_BITS-1:0]   adc_sample_i   = '0;
  logic                  window_start_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [SUM_W-1:0]      window_sum_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i    = CFG_PEDESTAL;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  pulse_sum_scoreboard sb;
  int samples_sent = 0;
  int writes_done  = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  bit no_gaps      = 1'b0;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;

  eight_sample_pulse_sum uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .adc_sample_i   (adc_sample_i),
    .window_start_i (window_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .window_sum_o   (window_sum_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_sum(window_sum_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no word moved for %0d cycles, %0d sums outstanding",
                 idle_cycles, sb.sums_due.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // output stall: segments of none / light / heavy / toggling, plus one long hold
  initial begin
    int style;
    int span;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        if (hold_req && !hold_done) begin
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          out_stall_i <= 1'b0;
          hold_done = 1'b1;
        end else begin
          case (style)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= ~out_stall_i;
          endcase
        end
      end
    end
  end

  task automatic send_sample(logic [ADC_BITS-1:0] s, logic start);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    adc_sample_i   <= s;
    window_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s, start);
    samples_sent++;
  endtask

  task automatic send_window(int shape, logic marked, int len);
    int w[WINDOW_LEN];
    int base;
    int step;
    int peak;
    int offset;
    base = $urandom_range(0, ADC_MAX);
    step = $urandom_range(0, 150);
    peak = $urandom_range(0, WINDOW_LEN - 1);
    for (int i = 0; i < WINDOW_LEN; i++) begin
      offset = (i > peak) ? i - peak : peak - i;
      case (shape)
        SHAPE_RISING:  w[i] = base + i * step;
        SHAPE_FALLING: w[i] = base - i * step;
        SHAPE_FLAT:    w[i] = base;
        SHAPE_PULSE:   w[i] = base - offset * step * 3;
        SHAPE_EXTREME: w[i] = ($urandom_range(0, 1) != 0) ? ADC_MAX : 0;
        SHAPE_TINY:    w[i] = $urandom_range(0, 15);
        default:       w[i] = $urandom_range(0, ADC_MAX);
      endcase
      if (w[i] < 0) w[i] = 0;
      if (w[i] > ADC_MAX) w[i] = ADC_MAX;
    end
    for (int i = 0; i < len; i++) begin
      send_sample(ADC_BITS'(w[i]), (i == 0) ? marked : 1'b0);
    end
  endtask

  // mostly marked full windows; some unmarked ones, cut-short windows and noise
  task automatic run_phase(int n);
    int first;
    int pick;
    first = samples_sent;
    while (samples_sent - first < n) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_sample(ADC_BITS'($urandom), $urandom_range(0, 3) == 0);
        end
      end else if (pick == 1) begin
        send_window($urandom_range(SHAPE_RANDOM, SHAPE_COUNT - 1), 1'b1,
                    $urandom_range(1, WINDOW_LEN - 1));
      end else begin
        send_window($urandom_range(SHAPE_RANDOM, SHAPE_COUNT - 1), pick != 2,
                    WINDOW_LEN);
      end
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.sums_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic [PED_W-1:0] ped, logic mode);
    logic [CFG_DATA_W-1:0] word;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_PEDESTAL;
    cfg_data_i  <= ped;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.pedestal = ped;
    word    = CFG_DATA_W'($urandom);
    word[0] = mode;
    cfg_index_i <= CFG_SUM_MODE;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.sum_mode = mode;
    cfg_valid_i <= 1'b0;
    writes_done += 2;
  endtask

  initial begin
    logic [PED_W-1:0] peds[NUM_PHASES];
    logic             modes[NUM_PHASES];
    sb = new();
    peds[0] = '0;                                 modes[0] = MODE_RISE_FALL;
    peds[1] = PED_W'(PED_MAX);                    modes[1] = MODE_PLAIN;
    peds[2] = '0;                                 modes[2] = MODE_PLAIN;
    peds[3] = PED_W'($urandom_range(0, 300));     modes[3] = MODE_PLAIN;
    peds[4] = PED_W'(PED_MAX);                    modes[4] = MODE_RISE_FALL;
    peds[5] = PED_W'($urandom_range(0, PED_MAX)); modes[5] = MODE_RISE_FALL;
    peds[6] = PED_W'($urandom_range(0, 600));     modes[6] = MODE_RISE_FALL;
    peds[7] = PED_W'($urandom_range(0, PED_MAX)); modes[7] = MODE_PLAIN;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first window right after reset carries no marker; flat, so it zeroes
    for (int i = 0; i < WINDOW_LEN; i++) send_sample(ADC_BITS'(100), 1'b0);
    // rise at sample 1, full-scale tail
    for (int i = 0; i < WINDOW_LEN; i++) begin
      send_sample((i == 0) ? '0 : ADC_BITS'(ADC_MAX), i == 0);
    end
    // marker inside a window drops the partial sum
    send_sample(ADC_BITS'(5), 1'b1);
    send_sample(ADC_BITS'(6), 1'b0);
    for (int i = 0; i < WINDOW_LEN; i++) send_sample(ADC_BITS'(ADC_MAX - i * 512), i == 0);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_config(peds[p], modes[p]);
      if (p == 3) begin
        no_gaps  = 1'b1;
        hold_req = 1'b1;
      end
      run_phase(PHASE_SAMPLES);
      no_gaps = 1'b0;
      settle();
    end

    $display("%0d samples in, %0d window sums checked, %0d register writes",
             samples_sent, sb.sums_checked, writes_done);
    $display("pedestal 0 to full scale in both modes, with a %0d-cycle output hold",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.sums_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
